>>> design/bounding_sphere_from_vertices_macros.svh
// ---------------------------------------------------------------------------
// bounding_sphere_from_vertices_macros.svh
// assertion helpers used by the sphere radius top-level design file
// ---------------------------------------------------------------------------
`ifndef BOUNDING_SPHERE_FROM_VERTICES_MACROS_SVH
`define BOUNDING_SPHERE_FROM_VERTICES_MACROS_SVH

// same-cycle implication, idle during reset
`define BSFV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define BSFV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bsfv_pkg.sv
// ---------------------------------------------------------------------------
// bsfv_pkg
// shared types and constants of the bounding sphere radius block
// ---------------------------------------------------------------------------
package bsfv_pkg;

  // scale register, unsigned Q8.8
  localparam int          SCALE_BITS  = 16;
  localparam logic [15:0] SCALE_RESET = 16'd256;

  // radius output width and the shift that drops the extra fraction bits
  localparam int RADIUS_BITS = 40;
  localparam int FRAC_SHIFT  = 9;

  // per-lane control strobes
  typedef struct packed {
    logic load;    // a vertex transfer updates the corners
    logic seed;    // the vertex starts a new set
    logic square;  // capture the squared extent
  } lane_ctl_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_TRACK  = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_SUM    = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_SCALE  = 5'b10000
  } state_t;

endpackage

>>> design/bsfv_if.sv
// ---------------------------------------------------------------------------
// bsfv_if
// valid/ready channel interfaces for vertices, radius results and the scale
// ---------------------------------------------------------------------------

// vertex channel
interface bsfv_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         last_vertex;

  modport source (output valid, coord_x, coord_y, coord_z, last_vertex, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_vertex, output ready);
endinterface

// radius channel
interface bsfv_out_if;
  logic                              valid;
  logic                              ready;
  logic [bsfv_pkg::RADIUS_BITS-1:0]  sphere_radius;

  modport source (output valid, sphere_radius, input ready);
  modport sink   (input valid, sphere_radius, output ready);
endinterface

// scale register write channel
interface bsfv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bsfv_pkg::SCALE_BITS-1:0]  scale_factor;

  modport source (output valid, scale_factor, input ready);
  modport sink   (input valid, scale_factor, output ready);
endinterface

>>> design/bounding_sphere_from_vertices.sv
// ---------------------------------------------------------------------------
// bounding_sphere_from_vertices
// Steps: after a last vertex the lanes register the squared extents, then the
//   root unit runs and the scaled radius goes to the output register.
// Throughput: one vertex per cycle inside a set; after a last vertex the
//   vertex channel is held off until the radius reaches the output register.
// Reset (rst_n, synchronous): scale = 1.0, next vertex starts a new set.
// ---------------------------------------------------------------------------
`include "bounding_sphere_from_vertices_macros.svh"

module bounding_sphere_from_vertices #(
  parameter int COORD_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  bsfv_in_if.sink           in_if,
  bsfv_out_if.source        out_if,
  bsfv_cfg_if.sink          cfg_if
);

  localparam int ROOT_BITS = COORD_BITS + 1;
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int SUM_BITS  = 2 * ROOT_BITS;
  localparam int PROD_BITS = ROOT_BITS + bsfv_pkg::SCALE_BITS;
  localparam int SHR_BITS  = PROD_BITS - bsfv_pkg::FRAC_SHIFT;

  bsfv_pkg::state_t                  state_r, state_nxt;
  logic                              awaiting_first_r;
  logic [bsfv_pkg::SCALE_BITS-1:0]   scale_r;
  logic [PROD_BITS-1:0]              prod_r;
  logic [bsfv_pkg::RADIUS_BITS-1:0]  radius_r;
  logic                              out_valid_r;
  logic                              in_acc;
  logic                              out_free;
  logic                              emit;
  bsfv_pkg::lane_ctl_t               lane_ctl;
  logic signed [COORD_BITS-1:0]      coords [3];
  logic [SQ_BITS-1:0]                sq [3];
  logic [SUM_BITS-1:0]               sum;
  logic                              root_done;
  logic [ROOT_BITS-1:0]              root;
  logic [SHR_BITS-1:0]               scaled;

  // handshakes
  assign in_if.ready  = (state_r == bsfv_pkg::ST_TRACK);
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_free     = !out_valid_r || out_if.ready;
  assign emit         = (state_r == bsfv_pkg::ST_SCALE) && out_free;

  // lane control
  assign lane_ctl.load   = in_acc;
  assign lane_ctl.seed   = awaiting_first_r;
  assign lane_ctl.square = (state_r == bsfv_pkg::ST_SQUARE);

  assign coords[0] = in_if.coord_x;
  assign coords[1] = in_if.coord_y;
  assign coords[2] = in_if.coord_z;

  // one lane per axis
  for (genvar g = 0; g < 3; g++) begin : g_lane
    bsfv_lane #(.COORD_BITS(COORD_BITS)) u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .coord (coords[g]),
      .sq    (sq[g])
    );
  end

  // merge: sum of squared extents feeds the root unit
  assign sum = SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);

  bsfv_isqrt #(.ROOT_BITS(ROOT_BITS)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == bsfv_pkg::ST_SUM),
    .radicand (sum),
    .done     (root_done),
    .root     (root)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsfv_pkg::ST_TRACK:  if (in_acc && in_if.last_vertex) state_nxt = bsfv_pkg::ST_SQUARE;
      bsfv_pkg::ST_SQUARE: state_nxt = bsfv_pkg::ST_SUM;
      bsfv_pkg::ST_SUM:    state_nxt = bsfv_pkg::ST_ROOT;
      bsfv_pkg::ST_ROOT:   if (root_done) state_nxt = bsfv_pkg::ST_SCALE;
      bsfv_pkg::ST_SCALE:  if (emit) state_nxt = bsfv_pkg::ST_TRACK;
      default:             state_nxt = bsfv_pkg::ST_TRACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= bsfv_pkg::ST_TRACK;
      awaiting_first_r <= 1'b1;
      scale_r          <= bsfv_pkg::SCALE_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        awaiting_first_r <= in_if.last_vertex;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        scale_r <= cfg_if.scale_factor;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // root times scale, then shift out the scale fraction and halve; with at most
  // 32 coordinate bits the shifted product always fits the radius width
  assign scaled = prod_r[PROD_BITS-1:bsfv_pkg::FRAC_SHIFT];

  always_ff @(posedge clk) begin
    if (root_done) begin
      prod_r <= root * scale_r;
    end
    if (emit) begin
      radius_r <= bsfv_pkg::RADIUS_BITS'(scaled);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.sphere_radius = radius_r;

  // checks
  `BSFV_ASSERT_NEXT(a_last_starts_calc, clk, rst_n, in_acc && in_if.last_vertex, (state_r == bsfv_pkg::ST_SQUARE) && awaiting_first_r, "last vertex did not start the radius calculation")
  `BSFV_ASSERT_SAME(a_root_in_root_state, clk, rst_n, root_done, state_r == bsfv_pkg::ST_ROOT, "square root finished outside its state")
  `BSFV_ASSERT_NEXT(a_emit_shows_result, clk, rst_n, emit, out_valid_r && (state_r == bsfv_pkg::ST_TRACK), "radius not presented after emit")

endmodule

>>> design/bsfv_lane.sv
// ---------------------------------------------------------------------------
// bsfv_lane
// one axis: running min/max of the set and the squared extent
// ---------------------------------------------------------------------------
module bsfv_lane #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  bsfv_pkg::lane_ctl_t           ctl,
  input  logic signed [COORD_BITS-1:0]  coord,
  output logic [2*COORD_BITS-1:0]       sq
);

  logic signed [COORD_BITS-1:0] min_r, min_nxt;
  logic signed [COORD_BITS-1:0] max_r, max_nxt;
  logic [COORD_BITS-1:0]        ext;
  logic [2*COORD_BITS-1:0]      sq_r;

  // corner update, first vertex of a set seeds both
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.load) begin
      if (ctl.seed) begin
        min_nxt = coord;
        max_nxt = coord;
      end else begin
        if (coord < min_r) min_nxt = coord;
        if (coord > max_r) max_nxt = coord;
      end
    end
  end

  // extent is never negative, so it fits unsigned in the coordinate width
  assign ext = COORD_BITS'(max_r - min_r);

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
    if (ctl.square) begin
      sq_r <= ext * ext;
    end
  end

  assign sq = sq_r;

endmodule

>>> design/bsfv_isqrt.sv
// ---------------------------------------------------------------------------
// bsfv_isqrt
// restoring integer square root, one root bit per cycle
// ---------------------------------------------------------------------------
module bsfv_isqrt #(
  parameter int ROOT_BITS = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [2*ROOT_BITS-1:0] radicand,
  output logic                   done,
  output logic [ROOT_BITS-1:0]   root
);

  localparam int CNT_W = $clog2(ROOT_BITS);
  localparam int REM_W = ROOT_BITS + 2;

  logic [2*ROOT_BITS-1:0] rad_r;
  logic [REM_W-1:0]       rem_r;
  logic [ROOT_BITS-1:0]   root_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       trial;
  logic                   fits;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_r[ROOT_BITS-1:0], rad_r[2*ROOT_BITS-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*ROOT_BITS-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the bounding sphere radius block: vertex sets go in over the vertex
// channel, a behavioral tracker of the box corners predicts each radius, and
// every radius transfer is compared with the oldest prediction. The scale
// register is rewritten between sets, both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int COORD_BITS   = 24;
  localparam int WATCH_LIMIT  = 1000;
  localparam int SETTLE_WAIT  = COORD_BITS + 16;
  localparam int PHASE_ITEMS  = 133;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [COORD_BITS-1:0]     coord_t;
  typedef logic [bsfv_pkg::RADIUS_BITS-1:0] radius_t;
  typedef logic [bsfv_pkg::SCALE_BITS-1:0]  scale_t;

  typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_CORNERS} set_style_t;

  localparam coord_t  COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t  COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam radius_t RADIUS_TOP = {bsfv_pkg::RADIUS_BITS{1'b1}};

  logic clk;
  logic rst_n;

  bsfv_in_if #(.COORD_BITS(COORD_BITS)) in_ch();
  bsfv_out_if                           out_ch();
  bsfv_cfg_if                           cfg_ch();

  bounding_sphere_from_vertices #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // box tracker state
  coord_t  min_corner [3];
  coord_t  max_corner [3];
  logic    seed_next;
  scale_t  scale_reg;
  radius_t radius_expected_q [$];

  // run bookkeeping
  int      fail_count;
  int      vertices_sent;
  int      sets_closed;
  int      radii_checked;
  int      scale_writes;
  int      idle_cycles;
  bit      burst_run;
  bit      ready_calm;
  int      stall_left;
  int      ready_window;
  radius_t expected_radius;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // floor of the square root, one result bit per step
  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // half diagonal of the tracked box, scaled, integer result
  function automatic radius_t radius_of_box();
    longint          diff;
    longint unsigned extent;
    longint unsigned sum_sq;
    longint unsigned root;
    longint unsigned scaled;
    sum_sq = 0;
    for (int k = 0; k < 3; k++) begin
      diff   = longint'(max_corner[k]) - longint'(min_corner[k]);
      extent = (diff > 0) ? longint'(diff) : 0;
      sum_sq = sum_sq + extent * extent;
    end
    root   = isqrt64(sum_sq);
    scaled = (root * longint'(scale_reg)) >> bsfv_pkg::FRAC_SHIFT;
    if (scaled > longint'(RADIUS_TOP)) return RADIUS_TOP;
    return radius_t'(scaled);
  endfunction

  // corner update for one accepted vertex, queues a radius on a last vertex
  task automatic track_vertex(input coord_t x, input coord_t y, input coord_t z,
                              input logic last);
    coord_t c [3];
    c[0] = x;
    c[1] = y;
    c[2] = z;
    for (int k = 0; k < 3; k++) begin
      if (seed_next) begin
        min_corner[k] = c[k];
        max_corner[k] = c[k];
      end else begin
        if (c[k] < min_corner[k]) min_corner[k] = c[k];
        if (c[k] > max_corner[k]) max_corner[k] = c[k];
      end
    end
    seed_next = 1'b0;
    if (last) begin
      radius_expected_q.push_back(radius_of_box());
      seed_next   = 1'b1;
      sets_closed = sets_closed + 1;
    end
  endtask

  // one vertex transfer, valid stays high across back-to-back items
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    int gap;
    gap = burst_run ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.coord_x     <= x;
    in_ch.coord_y     <= y;
    in_ch.coord_z     <= z;
    in_ch.last_vertex <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    track_vertex(x, y, z, last);
    vertices_sent = vertices_sent + 1;
  endtask

  // stop sending, wait for every radius, then let the pipeline empty
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (radius_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // scale register write, only with the block idle
  task automatic write_scale(input scale_t value);
    settle_block();
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.scale_factor <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    scale_reg    = value;
    scale_writes = scale_writes + 1;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // coordinate for one random set
  function automatic coord_t pick_coord(input set_style_t style, input int center);
    case (style)
      SPREAD_FULL: begin
        return coord_t'($urandom());
      end
      SPREAD_CLUSTER: begin
        return coord_t'(center + int'($urandom_range(0, 8191)) - 4096);
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return '1;
          4: return coord_t'(1);
          default: return coord_t'($urandom());
        endcase
      end
    endcase
  endfunction

  // one complete set with random length, spread and pacing
  task automatic send_random_set(output int count);
    set_style_t style;
    int         center;
    int         len;
    style     = set_style_t'($urandom_range(0, 2));
    center    = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    len       = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 24);
    burst_run = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      send_vertex(pick_coord(style, center), pick_coord(style, center),
                  pick_coord(style, center), (i == len - 1));
    end
    burst_run = 1'b0;
    count     = len;
  endtask

  // last vertex straight after reset, default scale
  task automatic test_first_after_reset();
    send_vertex(coord_t'(5), coord_t'(-7), coord_t'(100), 1'b1);
    send_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
  endtask

  // full-range corners and sign changes at unit scale
  task automatic test_coordinate_extremes();
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex('1, coord_t'(1), '1, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(coord_t'(1), '1, coord_t'(1), 1'b1);
    send_vertex(coord_t'(256), coord_t'(-256), coord_t'(512), 1'b0);
    send_vertex(coord_t'(-256), coord_t'(256), coord_t'(-512), 1'b1);
  endtask

  // scale register at its extremes and at the smallest step
  task automatic test_scale_extremes();
    write_scale('1);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    write_scale('0);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    write_scale(scale_t'(1));
    send_vertex(COORD_MIN, coord_t'(0), coord_t'(1000), 1'b0);
    send_vertex(COORD_MAX, coord_t'(4096), coord_t'(-1000), 1'b1);
  endtask

  // random sets over a sweep of scale values
  task automatic test_random_sets();
    scale_t sweep [6];
    int     phase_items;
    int     count;
    sweep[0] = '1;
    sweep[1] = '0;
    sweep[2] = scale_t'(1);
    sweep[3] = scale_t'($urandom());
    sweep[4] = scale_t'($urandom());
    sweep[5] = bsfv_pkg::SCALE_RESET;
    for (int p = 0; p < 6; p++) begin
      write_scale(sweep[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_random_set(count);
        phase_items = phase_items + count;
      end
    end
  endtask

  // stimulus
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.coord_x       = '0;
    in_ch.coord_y       = '0;
    in_ch.coord_z       = '0;
    in_ch.last_vertex   = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.scale_factor = '0;
    for (int k = 0; k < 3; k++) begin
      min_corner[k] = '0;
      max_corner[k] = '0;
    end
    seed_next     = 1'b1;
    scale_reg     = bsfv_pkg::SCALE_RESET;
    fail_count    = 0;
    vertices_sent = 0;
    sets_closed   = 0;
    radii_checked = 0;
    scale_writes  = 0;
    burst_run     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_after_reset();
    test_coordinate_extremes();
    test_scale_extremes();
    test_random_sets();
    settle_block();

    $display("covered %0d vertices in %0d sets, %0d radii checked", vertices_sent,
             sets_closed, radii_checked);
    $display("scale written %0d times, including 0, 1 and full scale", scale_writes);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

  // result side ready: random stalls, with calm windows of no stalls
  initial begin
    out_ch.ready = 1'b1;
    stall_left   = 0;
    ready_window = 0;
    ready_calm   = 1'b0;
    forever begin
      @(negedge clk);
      ready_window = ready_window + 1;
      if (ready_window == 128) begin
        ready_window = 0;
        ready_calm   = ($urandom_range(0, 3) == 0);
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!ready_calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // radius check against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (radius_expected_q.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT)
          $display("radius with none expected: got %0d", out_ch.sphere_radius);
      end else begin
        expected_radius = radius_expected_q.pop_front();
        radii_checked   = radii_checked + 1;
        if (out_ch.sphere_radius !== expected_radius) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT)
            $display("radius mismatch: expected %0d, got %0d", expected_radius,
                     out_ch.sphere_radius);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCH_LIMIT) begin
      $display("no transfer for %0d cycles, %0d radii outstanding", WATCH_LIMIT,
               radius_expected_q.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
